// File: src/next_k_permutation_assert.svh
// Assertion macros for the next k-permutation checker
`ifndef NEXT_K_PERMUTATION_ASSERT_SVH
`define NEXT_K_PERMUTATION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NKP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NKP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nkp_pkg.sv
// Shared types, codes and constants of the next k-permutation engine
package nkp_pkg;

  localparam int DEF_MAX_ELEMENTS = 16;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam int COUNT_BITS     = 5;
  localparam int INDEX_BITS     = 4;
  localparam int VALUE_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_USE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHOSEN = 2'd1;

  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // memory read: one address or a pair
  typedef enum logic [2:0] {
    RD_NONE,
    RD_IDX,
    RD_EDGE_J,
    RD_I_I1,
    RD_I_J,
    RD_LO_HI
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_LO,
    WR_HI
  } wr_op_t;

  // scan index update
  typedef enum logic [2:0] {
    IX_HOLD,
    IX_J_INC,
    IX_J_DEC,
    IX_J_N1,
    IX_I_EDGE,
    IX_I_DEC
  } ix_op_t;

  // swap / flip pointer update
  typedef enum logic [2:0] {
    LH_HOLD,
    LH_EDGE_J,
    LH_TAIL_K,
    LH_I_J,
    LH_TAIL_I,
    LH_STEP
  } lh_op_t;

  typedef struct packed {
    rd_op_t rd_op;
    wr_op_t wr_op;
    ix_op_t ix_op;
    lh_op_t lh_op;
    logic   start_adv;
    logic   out_load;
    logic   out_kind;
    logic   out_more;
  } ctl_cmd_t;

  typedef struct packed {
    logic ge;
    logic j_lt_n;
    logic k_one;
    logic i_zero;
    logic j_next_is_i;
    logic lo_lt_hi;
  } dp_status_t;

endpackage

// File: src/next_k_permutation.sv
// Top level of the next lexicographic k-permutation engine
//
//   channel | direction | handshake         | word
//   --------+-----------+-------------------+----------------------------------------
//   in_     | in        | in_valid/in_stall | opcode, element_index, element_value
//   out_    | out       | out_valid/out_stall | result_kind, read_value, has_next
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load writes the element while idle; read fetches it, then loads the result register.
// Advance runs on one two-read, one-write element memory: a scan step reads and then
// evaluates, a swap reads, writes lo and writes hi, and each tail flip step checks and
// then swaps its pair.
// A result waiting under out_stall does not block loads; a read or advance is taken
// but holds in ST_FIN until that result is taken.
// rst_n is synchronous, active low; element memory is not cleared.
module next_k_permutation
  import nkp_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [INDEX_BITS-1:0]     in_element_index,
  input  logic [VALUE_BITS-1:0]     in_element_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_result_kind,
  output logic [VALUE_BITS-1:0]     out_read_value,
  output logic                      out_has_next,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]     cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       cfg_we;

  nkp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_we    (cfg_we),
    .cmd       (cmd),
    .status    (status)
  );

  nkp_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .status           (status),
    .out_result_kind  (out_result_kind),
    .out_read_value   (out_read_value),
    .out_has_next     (out_has_next)
  );

endmodule

// File: src/nkp_datapath.sv
// Element memory, scan pointers, count registers and result register
module nkp_datapath
  import nkp_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]     cfg_data,
  input  logic [INDEX_BITS-1:0]     in_element_index,
  input  logic [VALUE_BITS-1:0]     in_element_value,
  input  ctl_cmd_t                  cmd,
  output dp_status_t                status,
  output logic                      out_result_kind,
  output logic [VALUE_BITS-1:0]     out_read_value,
  output logic                      out_has_next
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  logic [COUNT_BITS-1:0]   n_cfg_r, k_cfg_r;
  logic [CW-1:0]           n_r, k_r, j_r, i_r, lo_r, hi_r;
  logic [CW-1:0]           n_clamp, k_clamp, edge_pos, i_inc;
  logic                    idx_ok_r, idx_in_ok;
  logic [ELEMENT_BITS-1:0] mem [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] rd_a_r, rd_b_r, wd;
  logic [AW-1:0]           ra, rb, wa;
  logic                    re_a, re_b, we;
  logic                    out_kind_r, out_more_r;
  logic [VALUE_BITS-1:0]   out_value_r;

  assign idx_in_ok = 32'(in_element_index) < MAX_ELEMENTS;
  assign edge_pos  = k_r - ONE;
  assign i_inc     = i_r + ONE;

  // saturate n to 1..MAX_ELEMENTS and k to 1..n
  always_comb begin
    if (n_cfg_r == '0) begin
      n_clamp = ONE;
    end else if (32'(n_cfg_r) > MAX_ELEMENTS) begin
      n_clamp = CW'(MAX_ELEMENTS);
    end else begin
      n_clamp = CW'(n_cfg_r);
    end
    if (k_cfg_r == '0) begin
      k_clamp = ONE;
    end else if (32'(k_cfg_r) > 32'(n_clamp)) begin
      k_clamp = n_clamp;
    end else begin
      k_clamp = CW'(k_cfg_r);
    end
  end

  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    ra   = '0;
    rb   = '0;
    case (cmd.rd_op)
      RD_IDX: begin
        re_a = 1'b1;
        ra   = AW'(in_element_index);
      end
      RD_EDGE_J: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = edge_pos[AW-1:0];
        rb   = j_r[AW-1:0];
      end
      RD_I_I1: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = i_r[AW-1:0];
        rb   = i_inc[AW-1:0];
      end
      RD_I_J: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = i_r[AW-1:0];
        rb   = j_r[AW-1:0];
      end
      RD_LO_HI: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = lo_r[AW-1:0];
        rb   = hi_r[AW-1:0];
      end
      default: ;
    endcase
  end

  // a swap writes lo with the hi word, then hi with the lo word
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    case (cmd.wr_op)
      WR_LOAD: begin
        we = idx_in_ok;
        wa = AW'(in_element_index);
        wd = ELEMENT_BITS'(in_element_value);
      end
      WR_LO: begin
        we = 1'b1;
        wa = lo_r[AW-1:0];
        wd = rd_b_r;
      end
      WR_HI: begin
        we = 1'b1;
        wa = hi_r[AW-1:0];
        wd = rd_a_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_r <= mem[ra];
    end
    if (re_b) begin
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r <= COUNT_RESET;
      k_cfg_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IN_USE: n_cfg_r <= cfg_data;
        CFG_CHOSEN: k_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_adv) begin
      n_r <= n_clamp;
      k_r <= k_clamp;
      j_r <= k_clamp;
    end else begin
      case (cmd.ix_op)
        IX_J_INC:  j_r <= j_r + ONE;
        IX_J_DEC:  j_r <= j_r - ONE;
        IX_J_N1:   j_r <= n_r - ONE;
        IX_I_EDGE: i_r <= k_r - TWO;
        IX_I_DEC:  i_r <= i_r - ONE;
        default: ;
      endcase
    end
    case (cmd.lh_op)
      LH_EDGE_J: begin
        lo_r <= edge_pos;
        hi_r <= j_r;
      end
      LH_TAIL_K: begin
        lo_r <= k_r;
        hi_r <= n_r - ONE;
      end
      LH_I_J: begin
        lo_r <= i_r;
        hi_r <= j_r;
      end
      LH_TAIL_I: begin
        lo_r <= i_inc;
        hi_r <= n_r - ONE;
      end
      LH_STEP: begin
        lo_r <= lo_r + ONE;
        hi_r <= hi_r - ONE;
      end
      default: ;
    endcase
    if (cmd.rd_op == RD_IDX) begin
      idx_ok_r <= idx_in_ok;
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_more_r <= cmd.out_more;
      if (cmd.out_kind == KIND_READ && idx_ok_r) begin
        out_value_r <= VALUE_BITS'(rd_a_r);
      end else begin
        out_value_r <= '0;
      end
    end
  end

  assign status.ge          = rd_a_r >= rd_b_r;
  assign status.j_lt_n      = j_r < n_r;
  assign status.k_one       = k_r == ONE;
  assign status.i_zero      = i_r == '0;
  assign status.j_next_is_i = j_r == i_inc;
  assign status.lo_lt_hi    = lo_r < hi_r;

  assign out_result_kind = out_kind_r;
  assign out_read_value  = out_value_r;
  assign out_has_next    = out_more_r;

endmodule

// File: src/nkp_ctrl.sv
// Sequencer for load, read and advance words
module nkp_ctrl
  import nkp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic       cfg_we,
  output ctl_cmd_t   cmd,
  input  dp_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S1_RD,
    ST_S1_EV,
    ST_SW_RD,
    ST_SW_WL,
    ST_SW_WH,
    ST_F_CHK,
    ST_S2_RD,
    ST_S2_EV,
    ST_S3_RD,
    ST_S3_EV,
    ST_FIN
  } state_t;

  // which swap or flip the shared swap states serve
  typedef enum logic [1:0] {
    PH_EDGE,
    PH_FLIP1,
    PH_IJ,
    PH_FLIP2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic   fin_kind_r, fin_kind_nxt;
  logic   fin_more_r, fin_more_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    fin_kind_nxt  = fin_kind_r;
    fin_more_nxt  = fin_more_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{rd_op: RD_NONE, wr_op: WR_NONE, ix_op: IX_HOLD, lh_op: LH_HOLD,
                      default: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD: cmd.wr_op = WR_LOAD;
            OP_READ: begin
              cmd.rd_op    = RD_IDX;
              fin_kind_nxt = KIND_READ;
              fin_more_nxt = 1'b0;
              state_nxt    = ST_FIN;
            end
            OP_ADVANCE: begin
              cmd.start_adv = 1'b1;
              state_nxt     = ST_S1_RD;
            end
            default: ;
          endcase
        end
      end
      // look past k for the first element above the edge
      ST_S1_RD: begin
        if (status.j_lt_n) begin
          cmd.rd_op = RD_EDGE_J;
          state_nxt = ST_S1_EV;
        end else begin
          cmd.lh_op = LH_TAIL_K;
          ph_nxt    = PH_FLIP1;
          state_nxt = ST_F_CHK;
        end
      end
      ST_S1_EV: begin
        if (status.ge) begin
          cmd.ix_op = IX_J_INC;
          state_nxt = ST_S1_RD;
        end else begin
          cmd.lh_op = LH_EDGE_J;
          ph_nxt    = PH_EDGE;
          state_nxt = ST_SW_RD;
        end
      end
      ST_SW_RD: begin
        cmd.rd_op = RD_LO_HI;
        state_nxt = ST_SW_WL;
      end
      ST_SW_WL: begin
        cmd.wr_op = WR_LO;
        state_nxt = ST_SW_WH;
      end
      ST_SW_WH: begin
        cmd.wr_op = WR_HI;
        case (ph_r)
          PH_EDGE: begin
            fin_kind_nxt = KIND_ADVANCE;
            fin_more_nxt = 1'b1;
            state_nxt    = ST_FIN;
          end
          PH_IJ: begin
            cmd.lh_op = LH_TAIL_I;
            ph_nxt    = PH_FLIP2;
            state_nxt = ST_F_CHK;
          end
          default: begin
            cmd.lh_op = LH_STEP;
            state_nxt = ST_F_CHK;
          end
        endcase
      end
      ST_F_CHK: begin
        if (status.lo_lt_hi) begin
          state_nxt = ST_SW_RD;
        end else if (ph_r == PH_FLIP2) begin
          fin_kind_nxt = KIND_ADVANCE;
          fin_more_nxt = 1'b1;
          state_nxt    = ST_FIN;
        end else if (status.k_one) begin
          fin_kind_nxt = KIND_ADVANCE;
          fin_more_nxt = 1'b0;
          state_nxt    = ST_FIN;
        end else begin
          cmd.ix_op = IX_I_EDGE;
          state_nxt = ST_S2_RD;
        end
      end
      // walk left for the last ascent before the edge
      ST_S2_RD: begin
        cmd.rd_op = RD_I_I1;
        state_nxt = ST_S2_EV;
      end
      ST_S2_EV: begin
        if (!status.ge) begin
          cmd.ix_op = IX_J_N1;
          state_nxt = ST_S3_RD;
        end else if (status.i_zero) begin
          fin_kind_nxt = KIND_ADVANCE;
          fin_more_nxt = 1'b0;
          state_nxt    = ST_FIN;
        end else begin
          cmd.ix_op = IX_I_DEC;
          state_nxt = ST_S2_RD;
        end
      end
      // walk left from n-1 for the swap partner of i
      ST_S3_RD: begin
        cmd.rd_op = RD_I_J;
        state_nxt = ST_S3_EV;
      end
      ST_S3_EV: begin
        if (!status.ge) begin
          cmd.lh_op = LH_I_J;
          ph_nxt    = PH_IJ;
          state_nxt = ST_SW_RD;
        end else if (status.j_next_is_i) begin
          // partner is i itself: the swap is a no-op, go straight to the flip
          cmd.lh_op = LH_TAIL_I;
          ph_nxt    = PH_FLIP2;
          state_nxt = ST_F_CHK;
        end else begin
          cmd.ix_op = IX_J_DEC;
          state_nxt = ST_S3_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = fin_kind_r;
          cmd.out_more  = fin_more_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_EDGE;
      fin_kind_r  <= KIND_READ;
      fin_more_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      fin_kind_r  <= fin_kind_nxt;
      fin_more_r  <= fin_more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/nkp_checker.sv
// Port-level checks of the next k-permutation engine, bound to the top level
`include "next_k_permutation_assert.svh"

module nkp_checker
  import nkp_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_opcode,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_result_kind,
  input logic [VALUE_BITS-1:0]     out_read_value,
  input logic                      out_has_next,
  input logic                      cfg_ready
);

  `NKP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped under stall")
  `NKP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_read_value) && $stable(out_has_next) && $stable(out_result_kind), "result word changed under stall")
  `NKP_ASSERT_NOW(a_kind_fields, out_valid, (out_result_kind == KIND_READ && !out_has_next) || (out_result_kind == KIND_ADVANCE && out_read_value == '0), "result fields disagree with result kind")
  `NKP_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && in_opcode == OP_LOAD, !$rose(out_valid), "load word produced a result")
  `NKP_ASSERT_NOW(a_cfg_idle, cfg_ready, !in_stall, "config port open while busy")

endmodule

bind next_k_permutation nkp_checker u_nkp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_read_value  (out_read_value),
  .out_has_next    (out_has_next),
  .cfg_ready       (cfg_ready)
);

// File: dv/next_k_permutation_tb.sv
// Self-checking testbench for the next lexicographic k-permutation engine
`timescale 1ns / 100ps

module next_k_permutation_tb;
  import nkp_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam int ENTRIES = DEF_MAX_ELEMENTS;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 400;

  localparam logic [COUNT_BITS-1:0] PHASE_N [0:PHASES-1] =
    '{5'd4, 5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd6, 5'd3, 5'd16, 5'd2, 5'd7, 5'd8};
  localparam logic [COUNT_BITS-1:0] PHASE_K [0:PHASES-1] =
    '{5'd2, 5'd1, 5'd1, 5'd5, 5'd0, 5'd20, 5'd3, 5'd7, 5'd16, 5'd2, 5'd4, 5'd8};
  localparam logic [VALUE_BITS-1:0] FIRST_FILL [0:ENTRIES-1] =
    '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001,
      16'hFFFF, 16'h1234, 16'h0000, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h8000, 16'h0002};

  typedef struct packed {
    logic [1:0]            opcode;
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] value;
  } op_word_t;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
    logic                  more;
  } result_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_opcode = OP_LOAD;
  logic [INDEX_BITS-1:0]     in_element_index = '0;
  logic [VALUE_BITS-1:0]     in_element_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_result_kind;
  logic [VALUE_BITS-1:0]     out_read_value;
  logic                      out_has_next;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_IN_USE;
  logic [COUNT_BITS-1:0]     cfg_data = COUNT_RESET;

  op_word_t     pending_words [$];
  result_word_t awaited_results [$];
  bit           in_fire;
  int           mismatch_count = 0;
  int           send_idle_pct = 19;
  int           recv_stall_pct = 46;
  int           long_hold_asked = 0;
  int           long_hold_served = 0;
  int           hold_left = 0;

  // predictor copy of the element array and the two count registers
  logic [VALUE_BITS-1:0] perm_store [0:ENTRIES-1];
  logic [COUNT_BITS-1:0] model_in_use = COUNT_RESET;
  logic [COUNT_BITS-1:0] model_chosen = COUNT_RESET;

  always #5 clk = ~clk;

  next_k_permutation u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_read_value   (out_read_value),
    .out_has_next     (out_has_next),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic void swap_entries(int a, int b);
    logic [VALUE_BITS-1:0] t;
    t = perm_store[a];
    perm_store[a] = perm_store[b];
    perm_store[b] = t;
  endfunction

  function automatic void reverse_from(int from, int n);
    int lo;
    int hi;
    lo = from;
    hi = n - 1;
    while (hi > lo) begin
      swap_entries(lo, hi);
      lo++;
      hi--;
    end
  endfunction

  // step the leading k of n entries to the next k-permutation, duplicates allowed
  function automatic bit next_arrangement(int n, int k);
    int pivot;
    int i;
    int j;
    pivot = k - 1;
    j = k;
    while (j < n && perm_store[pivot] >= perm_store[j]) j++;
    if (j < n) begin
      swap_entries(pivot, j);
      return 1'b1;
    end
    reverse_from(k, n);
    i = pivot - 1;
    while (i >= 0 && perm_store[i] >= perm_store[i + 1]) i--;
    if (i < 0) return 1'b0;
    j = n - 1;
    while (j > i && perm_store[i] >= perm_store[j]) j--;
    swap_entries(i, j);
    reverse_from(i + 1, n);
    return 1'b1;
  endfunction

  function automatic void apply_word(op_word_t w);
    int n;
    int k;
    result_word_t r;
    n = model_in_use;
    k = model_chosen;
    if (n < 1) n = 1;
    if (n > ENTRIES) n = ENTRIES;
    if (k < 1) k = 1;
    if (k > n) k = n;
    r = '0;
    case (w.opcode)
      OP_LOAD: perm_store[w.index] = w.value;
      OP_ADVANCE: begin
        r.kind = KIND_ADVANCE;
        r.more = next_arrangement(n, k);
        awaited_results.push_back(r);
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.value = perm_store[w.index];
        awaited_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [VALUE_BITS-1:0] want,
                                      logic [VALUE_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // monitor: track config writes, predict accepted words, check results
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IN_USE) model_in_use = cfg_data;
        else if (cfg_index == CFG_CHOSEN) model_chosen = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = {out_result_kind, out_read_value, out_has_next};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d value %h more %0d",
                   $time, got.kind, got.value, got.more);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", VALUE_BITS'(want.kind), VALUE_BITS'(got.kind));
          check_field("read_value", want.value, got.value);
          check_field("has_next", VALUE_BITS'(want.more), VALUE_BITS'(got.more));
        end
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        apply_word({in_opcode, in_element_index, in_element_value});
      end
    end
  end

  // driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    op_word_t w;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_opcode <= w.opcode;
        in_element_index <= w.index;
        in_element_value <= w.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with an occasional long hold
  always @(negedge clk) begin
    if (long_hold_asked != long_hold_served) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void queue_word(logic [1:0] op, int idx, int val);
    op_word_t w;
    w.opcode = op;
    w.index = INDEX_BITS'(idx);
    w.value = VALUE_BITS'(val);
    pending_words.push_back(w);
  endfunction

  // mostly advance bursts and load runs in random order, with reads and spare opcodes mixed in
  task automatic queue_random_words(int count);
    int made;
    int span;
    int first;
    int len;
    int burst;
    made = 0;
    while (made < count) begin
      case ($urandom_range(9))
        0, 1: begin
          span = ($urandom_range(2) == 0) ? 65535 : $urandom_range(1, 4);
          first = $urandom_range(ENTRIES - 1);
          len = $urandom_range(1, ENTRIES);
          for (int m = 0; m < len; m++)
            queue_word(OP_LOAD, (first + m) % ENTRIES, $urandom_range(span));
          made += len;
        end
        2: begin
          queue_word(OP_READ, $urandom_range(ENTRIES - 1), $urandom_range(65535));
          made++;
        end
        3: queue_word(OP_SPARE, $urandom_range(ENTRIES - 1), $urandom_range(65535));
        default: begin
          burst = $urandom_range(1, 12);
          for (int m = 0; m < burst; m++) begin
            queue_word(OP_ADVANCE, $urandom_range(ENTRIES - 1), $urandom_range(65535));
            if ($urandom_range(3) == 0) begin
              queue_word(OP_READ, $urandom_range(ENTRIES - 1), $urandom_range(65535));
              made++;
            end
          end
          made += burst;
        end
      endcase
    end
  endtask

  task automatic wait_engine_idle();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [COUNT_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every entry first so no read or advance touches an unwritten one
    for (int e = 0; e < ENTRIES; e++) queue_word(OP_LOAD, e, FIRST_FILL[e]);
    queue_word(OP_ADVANCE, 0, 0);
    queue_word(OP_READ, ENTRIES - 1, 0);
    queue_word(OP_SPARE, ENTRIES - 1, 16'hFFFF);
    wait_engine_idle();

    // descending triple: exhausted on the first advance
    write_register(CFG_IN_USE, 5'd3);
    write_register(CFG_CHOSEN, 5'd3);
    queue_word(OP_LOAD, 0, 3);
    queue_word(OP_LOAD, 1, 2);
    queue_word(OP_LOAD, 2, 1);
    queue_word(OP_ADVANCE, 0, 0);
    queue_word(OP_READ, 0, 0);
    queue_word(OP_READ, 2, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_engine_idle();
      if (phase == 4) begin
        send_idle_pct = 46;
        recv_stall_pct = 19;
      end
      if (phase == 8) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_register(CFG_IN_USE, PHASE_N[phase]);
      write_register(CFG_CHOSEN, PHASE_K[phase]);
      if (phase == 6) write_register(CFG_SPARE, 5'd5);
      if (phase == 2) begin
        // pause the sender until everything in flight has drained
        queue_random_words(PHASE_WORDS / 2);
        wait_engine_idle();
        queue_random_words(PHASE_WORDS - PHASE_WORDS / 2);
      end else begin
        queue_random_words(PHASE_WORDS);
      end
      if (phase == 5) long_hold_asked++;
    end
    wait_engine_idle();

    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: next_k_permutation.f
+incdir+src
src/nkp_pkg.sv
src/nkp_datapath.sv
src/nkp_ctrl.sv
src/next_k_permutation.sv
src/nkp_checker.sv
dv/next_k_permutation_tb.sv
